>>> hdl/bps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bps_pkg: shared types and constants of the beep pattern sequencer
// Operation and pattern codes, register map, configuration bundle and the
// beep length lookup.
// ---------------------------------------------------------------------------
package bps_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_PLAY      = 2'd1,
        OP_STOP      = 2'd2,
        OP_SPEED_LOW = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        PH_ON   = 2'd0,
        PH_OFF  = 2'd1,
        PH_IDLE = 2'd2
    } t_phase;

    localparam logic [2:0] PAT_QUALIFYING = 3'd0;
    localparam logic [2:0] PAT_QUALIFIED  = 3'd1;
    localparam logic [2:0] PAT_CLOSED     = 3'd2;
    localparam logic [2:0] PAT_SPEED_LOW  = 3'd3;
    localparam logic [2:0] PAT_PW_RESET   = 3'd4;

    localparam logic [7:0] PW_RESET_UNITS = 8'd50;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_SOUND_ENABLE = 3'd0;
    localparam logic [2:0] REG_QUALIFYING   = 3'd1;
    localparam logic [2:0] REG_QUALIFIED    = 3'd2;
    localparam logic [2:0] REG_CLOSED_BEEP  = 3'd3;
    localparam logic [2:0] REG_CLOSED_GAP   = 3'd4;
    localparam logic [2:0] REG_SPEED_LOW    = 3'd5;

    typedef struct packed {
        logic       sound_enable;
        logic [7:0] qualifying_units;
        logic [7:0] qualified_units;
        logic [7:0] closed_beep_units;
        logic [7:0] closed_gap_units;
        logic [7:0] speed_low_units;
    } t_cfg;

    function automatic logic [7:0] beep_units(input t_cfg cfg, input logic [2:0] pat);
        logic [7:0] units;
        case (pat)
            PAT_QUALIFYING: units = cfg.qualifying_units;
            PAT_QUALIFIED:  units = cfg.qualified_units;
            PAT_CLOSED:     units = cfg.closed_beep_units;
            PAT_SPEED_LOW:  units = cfg.speed_low_units;
            default:        units = PW_RESET_UNITS;
        endcase
        return units;
    endfunction

endpackage
`default_nettype wire

>>> hdl/bps_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bps_regs: configuration register file
// APB-style write and read access to the six sequencer settings.
// ---------------------------------------------------------------------------
module bps_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [bps_pkg::ADDR_W-1:0] paddr,
    input  wire logic [bps_pkg::DATA_W-1:0] pwdata,
    output logic      [bps_pkg::DATA_W-1:0] prdata,
    output bps_pkg::t_cfg                   o_cfg
);

    bps_pkg::t_cfg r_cfg;
    logic [2:0]    w_idx;
    logic          w_wr;

    assign w_idx = paddr[bps_pkg::ADDR_W-1:2];
    assign w_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sound_enable      <= 1'b1;
            r_cfg.qualifying_units  <= 8'd2;
            r_cfg.qualified_units   <= 8'd6;
            r_cfg.closed_beep_units <= 8'd2;
            r_cfg.closed_gap_units  <= 8'd2;
            r_cfg.speed_low_units   <= 8'd10;
        end else if (w_wr) begin
            case (w_idx)
                bps_pkg::REG_SOUND_ENABLE: r_cfg.sound_enable      <= pwdata[0];
                bps_pkg::REG_QUALIFYING:   r_cfg.qualifying_units  <= pwdata[7:0];
                bps_pkg::REG_QUALIFIED:    r_cfg.qualified_units   <= pwdata[7:0];
                bps_pkg::REG_CLOSED_BEEP:  r_cfg.closed_beep_units <= pwdata[7:0];
                bps_pkg::REG_CLOSED_GAP:   r_cfg.closed_gap_units  <= pwdata[7:0];
                bps_pkg::REG_SPEED_LOW:    r_cfg.speed_low_units   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            bps_pkg::REG_SOUND_ENABLE: prdata = {31'd0, r_cfg.sound_enable};
            bps_pkg::REG_QUALIFYING:   prdata = {24'd0, r_cfg.qualifying_units};
            bps_pkg::REG_QUALIFIED:    prdata = {24'd0, r_cfg.qualified_units};
            bps_pkg::REG_CLOSED_BEEP:  prdata = {24'd0, r_cfg.closed_beep_units};
            bps_pkg::REG_CLOSED_GAP:   prdata = {24'd0, r_cfg.closed_gap_units};
            bps_pkg::REG_SPEED_LOW:    prdata = {24'd0, r_cfg.speed_low_units};
            default:                   prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

>>> hdl/beep_pattern_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// beep_pattern_sequencer: buzzer beep pattern engine
// Plays single beeps and a multi-beep closed pattern, advanced by tick
// transactions; gives buzzer level and busy flag per transaction.
// ---------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------
//  input    | i_valid / o_ready  | i_op, i_pattern, i_active
//  output   | o_valid / i_ready  | o_buzzer_level, o_busy_res
//  config   | psel/penable/pready| pwrite, paddr, pwdata, prdata
//
//  One transaction per cycle while the output is not stalled: the state update is
//  one pass of logic into the phase registers and the result register.
//  o_ready is high while the result register is empty or being taken.
//  Synchronous active-low reset: idle, no result, default settings (level/busy regs not reset).
//  A stalled output holds its result and blocks further input only then.
// ---------------------------------------------------------------------------
module beep_pattern_sequencer #(
    parameter int CLOSED_BEEPS = 3
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [1:0]                 i_op,
    input  wire logic [2:0]                 i_pattern,
    input  wire logic                       i_active,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic                            o_buzzer_level,
    output logic                            o_busy_res,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [bps_pkg::ADDR_W-1:0] paddr,
    input  wire logic [bps_pkg::DATA_W-1:0] pwdata,
    output logic      [bps_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam logic [3:0] LP_CLOSED_STEPS = 4'(CLOSED_BEEPS);

    bps_pkg::t_cfg   w_cfg;
    bps_pkg::t_phase r_phase, n_phase;
    logic [2:0]      r_step, n_step;
    logic [7:0]      r_on_left, n_on_left;
    logic [7:0]      r_off_left, n_off_left;
    logic [2:0]      r_pat, n_pat;
    logic            r_out_valid;
    logic            r_level, n_level;
    logic            r_busy, n_busy;
    logic            w_accept;
    logic [3:0]      w_step_inc;
    logic [3:0]      w_step_cnt;
    logic            w_last_step;
    logic [7:0]      w_on_dec;
    logic [7:0]      w_off_dec;
    logic            w_start;
    logic [2:0]      w_start_pat;

    bps_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (w_cfg)
    );

    assign pready   = 1'b1;
    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    assign w_step_inc  = {1'b0, r_step} + 4'd1;
    assign w_step_cnt  = (r_pat == bps_pkg::PAT_CLOSED) ? LP_CLOSED_STEPS : 4'd1;
    assign w_last_step = (w_step_inc >= w_step_cnt);
    assign w_on_dec    = r_on_left - 8'd1;
    assign w_off_dec   = r_off_left - 8'd1;

    // play and speed-low start share one path
    always_comb begin
        w_start     = 1'b0;
        w_start_pat = i_pattern;
        if (i_op == bps_pkg::OP_PLAY) begin
            w_start = w_cfg.sound_enable &&
                      (i_pattern inside {[bps_pkg::PAT_QUALIFYING:bps_pkg::PAT_PW_RESET]});
        end else if (i_op == bps_pkg::OP_SPEED_LOW) begin
            w_start     = w_cfg.sound_enable && i_active;
            w_start_pat = bps_pkg::PAT_SPEED_LOW;
        end
    end

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_step     = r_step;
        n_on_left  = r_on_left;
        n_off_left = r_off_left;
        n_pat      = r_pat;
        if (w_start) begin
            n_pat      = w_start_pat;
            n_step     = '0;
            n_on_left  = bps_pkg::beep_units(w_cfg, w_start_pat);
            n_off_left = '0;
            n_phase    = bps_pkg::PH_ON;
        end else begin
            case (i_op)
                bps_pkg::OP_TICK: begin
                    case (r_phase)
                        bps_pkg::PH_ON: begin
                            n_on_left = w_on_dec;
                            if (w_on_dec == 8'd0) begin
                                if (r_pat == bps_pkg::PAT_CLOSED && !w_last_step &&
                                    w_cfg.closed_gap_units != 8'd0) begin
                                    n_off_left = w_cfg.closed_gap_units;
                                    n_phase    = bps_pkg::PH_OFF;
                                end else if (w_last_step) begin
                                    n_phase = bps_pkg::PH_IDLE;
                                end else begin
                                    n_step    = w_step_inc[2:0];
                                    n_on_left = bps_pkg::beep_units(w_cfg, r_pat);
                                end
                            end
                        end
                        bps_pkg::PH_OFF: begin
                            n_off_left = w_off_dec;
                            if (w_off_dec == 8'd0) begin
                                if (w_last_step) begin
                                    n_phase = bps_pkg::PH_IDLE;
                                end else begin
                                    n_step    = w_step_inc[2:0];
                                    n_on_left = bps_pkg::beep_units(w_cfg, r_pat);
                                    n_phase   = bps_pkg::PH_ON;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                bps_pkg::OP_STOP: begin
                    n_phase = bps_pkg::PH_IDLE;
                end
                bps_pkg::OP_SPEED_LOW: begin
                    // inactive update drops only a running speed-low beep
                    if (!i_active && r_pat == bps_pkg::PAT_SPEED_LOW &&
                        (r_phase == bps_pkg::PH_ON || r_phase == bps_pkg::PH_OFF)) begin
                        n_phase = bps_pkg::PH_IDLE;
                    end
                end
                default: ;
            endcase
        end
    end

    // outputs follow the next phase
    always_comb begin
        n_level = (n_phase == bps_pkg::PH_ON);
        n_busy  = (n_phase == bps_pkg::PH_ON) || (n_phase == bps_pkg::PH_OFF);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= bps_pkg::PH_IDLE;
            r_step      <= '0;
            r_on_left   <= '0;
            r_off_left  <= '0;
            r_pat       <= bps_pkg::PAT_QUALIFYING;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase    <= n_phase;
                r_step     <= n_step;
                r_on_left  <= n_on_left;
                r_off_left <= n_off_left;
                r_pat      <= n_pat;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_level <= n_level;
            r_busy  <= n_busy;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_buzzer_level = r_level;
    assign o_busy_res     = r_busy;

`ifndef SYNTHESIS
    a_off_has_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == bps_pkg::PH_OFF) |-> (r_off_left != 8'd0))
        else $error("off phase with empty gap countdown");

    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != bps_pkg::PH_IDLE) |-> ({1'b0, r_step} < w_step_cnt))
        else $error("step index past pattern length");

    a_stop_silences: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_op == bps_pkg::OP_STOP) |=>
        (o_valid && !o_busy_res && !o_buzzer_level))
        else $error("stop did not silence the buzzer");

    a_level_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_buzzer_level) |-> o_busy_res)
        else $error("buzzer sounding while idle");
`endif

endmodule
`default_nettype wire

>>> verif/beep_pattern_sequencer_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// beep_pattern_sequencer_tb: self-checking bench for the beep pattern engine
// Drives tick/play/stop/speed-low transactions with random gaps and output
// stalls, mirrors the pattern engine in a local model and compares buzzer
// level and busy flag of every result; covers disabled sound, zero and full
// length registers and long random pattern runs under several settings.
// ---------------------------------------------------------------------------
module beep_pattern_sequencer_tb;

    localparam int CLOSED_BEEPS = 3;
    localparam int RAND_ITEMS   = 1350;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE       = 4;

    typedef struct packed {
        logic level;
        logic busy;
    } t_beep;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    logic [1:0]                   i_op;
    logic [2:0]                   i_pattern;
    logic                         i_active;
    logic                         o_valid;
    logic                         i_ready = 1'b0;
    logic                         o_buzzer_level;
    logic                         o_busy_res;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [bps_pkg::ADDR_W-1:0]   paddr;
    logic [bps_pkg::DATA_W-1:0]   pwdata;
    logic [bps_pkg::DATA_W-1:0]   prdata;
    logic                         pready;

    // local copy of the engine
    bps_pkg::t_cfg   sim_cfg;
    bps_pkg::t_phase sim_phase;
    logic [2:0]      sim_step;
    logic [7:0]      sim_on_left;
    logic [7:0]      sim_off_left;
    logic [2:0]      sim_pat;
    logic            sim_level;

    t_beep pending_beeps[$];
    int    failures   = 0;
    int    cycles     = 0;
    int    stall_left = 0;
    bit    src_idle   = 1'b1;
    bit    snk_idle   = 1'b1;

    beep_pattern_sequencer #(
        .CLOSED_BEEPS(CLOSED_BEEPS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_pattern      (i_pattern),
        .i_active       (i_active),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_buzzer_level (o_buzzer_level),
        .o_busy_res     (o_busy_res),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // ---------------- model of the engine ----------------

    function automatic logic [7:0] units_for(logic [2:0] pat);
        case (pat)
            bps_pkg::PAT_QUALIFYING: return sim_cfg.qualifying_units;
            bps_pkg::PAT_QUALIFIED:  return sim_cfg.qualified_units;
            bps_pkg::PAT_CLOSED:     return sim_cfg.closed_beep_units;
            bps_pkg::PAT_SPEED_LOW:  return sim_cfg.speed_low_units;
            default:                 return bps_pkg::PW_RESET_UNITS;
        endcase
    endfunction

    function automatic int beeps_in(logic [2:0] pat);
        return (pat == bps_pkg::PAT_CLOSED) ? CLOSED_BEEPS : 1;
    endfunction

    function automatic void start_beep(logic [2:0] pat);
        if (!sim_cfg.sound_enable || pat > bps_pkg::PAT_PW_RESET)
            return;
        sim_pat      = pat;
        sim_step     = '0;
        sim_on_left  = units_for(pat);
        sim_off_left = '0;
        sim_phase    = bps_pkg::PH_ON;
        sim_level    = 1'b1;
    endfunction

    function automatic void next_beep();
        if (int'(sim_step) + 1 >= beeps_in(sim_pat)) begin
            sim_phase = bps_pkg::PH_IDLE;
            sim_level = 1'b0;
        end else begin
            sim_step    = sim_step + 3'd1;
            sim_on_left = units_for(sim_pat);
            sim_phase   = bps_pkg::PH_ON;
            sim_level   = 1'b1;
        end
    endfunction

    function automatic t_beep advance_buzzer(bps_pkg::t_op op, logic [2:0] pat, logic act);
        logic [7:0] gap;
        t_beep      res;
        case (op)
            bps_pkg::OP_TICK: begin
                if (sim_phase == bps_pkg::PH_ON) begin
                    sim_on_left = sim_on_left - 8'd1;
                    if (sim_on_left == 8'd0) begin
                        gap = '0;
                        if (sim_pat == bps_pkg::PAT_CLOSED &&
                            int'(sim_step) + 1 < beeps_in(sim_pat))
                            gap = sim_cfg.closed_gap_units;
                        if (gap != 8'd0) begin
                            sim_level    = 1'b0;
                            sim_off_left = gap;
                            sim_phase    = bps_pkg::PH_OFF;
                        end else begin
                            next_beep();
                        end
                    end
                end else if (sim_phase == bps_pkg::PH_OFF) begin
                    sim_off_left = sim_off_left - 8'd1;
                    if (sim_off_left == 8'd0)
                        next_beep();
                end
            end
            bps_pkg::OP_PLAY: start_beep(pat);
            bps_pkg::OP_STOP: begin
                sim_phase = bps_pkg::PH_IDLE;
                sim_level = 1'b0;
            end
            default: begin
                if (act) begin
                    start_beep(bps_pkg::PAT_SPEED_LOW);
                end else if (sim_pat == bps_pkg::PAT_SPEED_LOW &&
                             sim_phase != bps_pkg::PH_IDLE) begin
                    sim_phase = bps_pkg::PH_IDLE;
                    sim_level = 1'b0;
                end
            end
        endcase
        res.level = sim_level;
        res.busy  = (sim_phase == bps_pkg::PH_ON || sim_phase == bps_pkg::PH_OFF);
        return res;
    endfunction

    // ---------------- drivers ----------------

    // valid is left high after the transaction; drain() or the next gap drops it
    task automatic send_item(bps_pkg::t_op op, logic [2:0] pat, logic act);
        int gap;
        gap = 0;
        if (src_idle && $urandom_range(0, 2) == 0)
            gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_op      <= op;
        i_pattern <= pat;
        i_active  <= act;
        do @(posedge i_clk); while (!o_ready);
        pending_beeps.push_back(advance_buzzer(op, pat, act));
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_item(bps_pkg::OP_TICK, 3'($urandom_range(0, 7)),
                             1'($urandom_range(0, 1)));
    endtask

    task automatic send_noise();
        send_item(bps_pkg::t_op'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                  1'($urandom_range(0, 1)));
    endtask

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (snk_idle && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap() - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic apb_xfer(bit wr, logic [2:0] idx, logic [bps_pkg::DATA_W-1:0] wdata,
                            output logic [bps_pkg::DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_reg(logic [2:0] idx, logic [7:0] val);
        logic [bps_pkg::DATA_W-1:0] rd;
        logic [bps_pkg::DATA_W-1:0] want;
        apb_xfer(1'b1, idx, bps_pkg::DATA_W'(val), rd);
        case (idx)
            bps_pkg::REG_SOUND_ENABLE: sim_cfg.sound_enable      = val[0];
            bps_pkg::REG_QUALIFYING:   sim_cfg.qualifying_units  = val;
            bps_pkg::REG_QUALIFIED:    sim_cfg.qualified_units   = val;
            bps_pkg::REG_CLOSED_BEEP:  sim_cfg.closed_beep_units = val;
            bps_pkg::REG_CLOSED_GAP:   sim_cfg.closed_gap_units  = val;
            default:                   sim_cfg.speed_low_units   = val;
        endcase
        want = (idx == bps_pkg::REG_SOUND_ENABLE) ? bps_pkg::DATA_W'(val[0]) :
                                                    bps_pkg::DATA_W'(val);
        apb_xfer(1'b0, idx, '0, rd);
        if (rd !== want) begin
            $error("prdata of register %0d: expected %0h, actual %0h", idx, want, rd);
            failures++;
        end
    endtask

    task automatic load_cfg(logic en, logic [7:0] qfy, logic [7:0] qfd, logic [7:0] cb,
                            logic [7:0] cg, logic [7:0] sl);
        set_reg(bps_pkg::REG_SOUND_ENABLE, {7'd0, en});
        set_reg(bps_pkg::REG_QUALIFYING, qfy);
        set_reg(bps_pkg::REG_QUALIFIED, qfd);
        set_reg(bps_pkg::REG_CLOSED_BEEP, cb);
        set_reg(bps_pkg::REG_CLOSED_GAP, cg);
        set_reg(bps_pkg::REG_SPEED_LOW, sl);
    endtask

    // hold input until every result is back, then let the block settle
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_beeps.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // ---------------- result checker ----------------

    always @(posedge i_clk) begin
        t_beep want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_beeps.size() == 0) begin
                $error("unexpected transaction: buzzer_level=%0b busy_res=%0b",
                       o_buzzer_level, o_busy_res);
                failures++;
            end else begin
                want = pending_beeps.pop_front();
                if (o_buzzer_level !== want.level) begin
                    $error("buzzer_level: expected %0b, actual %0b", want.level, o_buzzer_level);
                    failures++;
                end
                if (o_busy_res !== want.busy) begin
                    $error("busy_res: expected %0b, actual %0b", want.busy, o_busy_res);
                    failures++;
                end
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_directed();
        send_item(bps_pkg::OP_TICK, bps_pkg::PAT_QUALIFYING, 1'b0);      // tick while idle
        send_item(bps_pkg::OP_PLAY, 3'd5, 1'b0);                         // unknown patterns
        send_item(bps_pkg::OP_PLAY, 3'd7, 1'b1);
        send_item(bps_pkg::OP_PLAY, bps_pkg::PAT_QUALIFYING, 1'b0);
        send_ticks(2);
        send_item(bps_pkg::OP_PLAY, bps_pkg::PAT_PW_RESET, 1'b0);
        send_ticks(1);
        send_item(bps_pkg::OP_PLAY, bps_pkg::PAT_QUALIFIED, 1'b0);       // restart mid-beep
        send_item(bps_pkg::OP_STOP, bps_pkg::PAT_QUALIFIED, 1'b1);
        send_ticks(1);
        send_item(bps_pkg::OP_SPEED_LOW, bps_pkg::PAT_QUALIFYING, 1'b0); // nothing playing
        send_item(bps_pkg::OP_PLAY, bps_pkg::PAT_SPEED_LOW, 1'b0);
        send_ticks(1);
        send_item(bps_pkg::OP_SPEED_LOW, bps_pkg::PAT_CLOSED, 1'b0);     // stops speed-low
        send_item(bps_pkg::OP_SPEED_LOW, 3'd7, 1'b1);
        send_item(bps_pkg::OP_PLAY, bps_pkg::PAT_CLOSED, 1'b0);
        send_item(bps_pkg::OP_SPEED_LOW, bps_pkg::PAT_SPEED_LOW, 1'b0);  // closed keeps on
        send_ticks(11);
        drain();
    endtask

    task automatic test_disabled();
        send_item(bps_pkg::OP_PLAY, bps_pkg::PAT_QUALIFIED, 1'b0);
        send_ticks(2);
        drain();
        set_reg(bps_pkg::REG_SOUND_ENABLE, 8'd0);
        send_item(bps_pkg::OP_PLAY, bps_pkg::PAT_QUALIFYING, 1'b0);
        send_item(bps_pkg::OP_SPEED_LOW, bps_pkg::PAT_QUALIFYING, 1'b1);
        send_item(bps_pkg::OP_PLAY, 3'd6, 1'b0);
        send_ticks(5);                                 // old beep still runs out
        send_item(bps_pkg::OP_PLAY, bps_pkg::PAT_CLOSED, 1'b0);
        drain();
        set_reg(bps_pkg::REG_SOUND_ENABLE, 8'd1);
        send_item(bps_pkg::OP_SPEED_LOW, bps_pkg::PAT_PW_RESET, 1'b1);
        send_ticks(3);
        drain();
        set_reg(bps_pkg::REG_SOUND_ENABLE, 8'd0);
        send_item(bps_pkg::OP_SPEED_LOW, bps_pkg::PAT_QUALIFYING, 1'b0); // inactive still stops
        send_item(bps_pkg::OP_STOP, bps_pkg::PAT_QUALIFYING, 1'b0);
        send_ticks(2);
        drain();
        set_reg(bps_pkg::REG_SOUND_ENABLE, 8'd1);
    endtask

    task automatic test_extreme_lengths();
        // zero loads wrap to 256 ticks, zero gap chains beeps back to back
        load_cfg(1'b1, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0);
        send_item(bps_pkg::OP_PLAY, bps_pkg::PAT_QUALIFYING, 1'b0);
        send_ticks(257);
        send_item(bps_pkg::OP_PLAY, bps_pkg::PAT_CLOSED, 1'b0);
        send_ticks(4);
        send_item(bps_pkg::OP_SPEED_LOW, bps_pkg::PAT_QUALIFYING, 1'b1);
        send_ticks(10);
        send_item(bps_pkg::OP_SPEED_LOW, bps_pkg::PAT_QUALIFYING, 1'b0);
        drain();
        load_cfg(1'b1, 8'd255, 8'd255, 8'd1, 8'd255, 8'd255);
        send_item(bps_pkg::OP_PLAY, bps_pkg::PAT_CLOSED, 1'b0);
        send_ticks(10);
        send_item(bps_pkg::OP_STOP, bps_pkg::PAT_CLOSED, 1'b0);
        send_item(bps_pkg::OP_PLAY, bps_pkg::PAT_QUALIFIED, 1'b0);
        send_ticks(256);
        drain();
    endtask

    function automatic logic [7:0] rand_units();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 8'd0;
        if (r == 1)
            return 8'd255;
        if (r < 4)
            return 8'($urandom_range(1, 255));
        return 8'($urandom_range(1, 6));
    endfunction

    task automatic test_random();
        int done;
        int quota;
        int reps;
        int set_no;
        done = 0;
        for (set_no = 0; done < RAND_ITEMS; set_no++) begin
            src_idle = (set_no % 3 != 2);
            snk_idle = (set_no % 4 != 3);
            load_cfg(1'($urandom_range(0, 5) != 0), rand_units(), rand_units(),
                     rand_units(), rand_units(), rand_units());
            quota = done + 240;
            while (done < quota && done < RAND_ITEMS) begin
                if ($urandom_range(0, 9) < 7) begin
                    if ($urandom_range(0, 4) == 0)
                        send_item(bps_pkg::OP_SPEED_LOW, 3'($urandom_range(0, 7)), 1'b1);
                    else
                        send_item(bps_pkg::OP_PLAY, 3'($urandom_range(0, 4)),
                                  1'($urandom_range(0, 1)));
                    done++;
                    reps = 0;
                    while (sim_phase != bps_pkg::PH_IDLE && reps < 600 && done < quota) begin
                        if ($urandom_range(0, 19) == 0)
                            send_noise();
                        else
                            send_ticks(1);
                        done++;
                        reps++;
                    end
                end else begin
                    send_noise();
                    done++;
                end
            end
            drain();
        end
        src_idle = 1'b1;
        snk_idle = 1'b1;
    endtask

    initial begin
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_op      <= bps_pkg::OP_TICK;
        i_pattern <= bps_pkg::PAT_QUALIFYING;
        i_active  <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        sim_cfg = '{sound_enable: 1'b1, qualifying_units: 8'd2, qualified_units: 8'd6,
                    closed_beep_units: 8'd2, closed_gap_units: 8'd2,
                    speed_low_units: 8'd10};
        sim_phase    = bps_pkg::PH_IDLE;
        sim_step     = '0;
        sim_on_left  = '0;
        sim_off_left = '0;
        sim_pat      = bps_pkg::PAT_QUALIFYING;
        sim_level    = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_disabled();
        test_extreme_lengths();
        test_random();
        drain();

        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
